[sv/rssp_pkg.sv]
// Types, codes and decode functions for the sensor packet parser.
// Used by every module of the block; depends on nothing.
package rssp_pkg;

  localparam int NumWords = 5;
  localparam int NumBytes = 4;
  localparam int AddrBits = 3;
  localparam int RegIndexBit = 2;

  typedef enum logic [1:0] {
    CMD_PACKET       = 2'd0,
    CMD_SET_RETURN   = 2'd1,
    CMD_CLEAR_RETURN = 2'd2
  } cmd_t;

  localparam logic CfgCleaningLimit = 1'b0;
  localparam logic CfgDockedLimit   = 1'b1;

  localparam logic signed [15:0] CleaningLimitReset = -16'sd400;
  localparam logic signed [15:0] DockedLimitReset   = -16'sd50;

  // staged word slots
  localparam logic [2:0] WordDistance = 3'd0;
  localparam logic [2:0] WordVoltage  = 3'd1;
  localparam logic [2:0] WordCurrent  = 3'd2;
  localparam logic [2:0] WordCharge   = 3'd3;
  localparam logic [2:0] WordCapacity = 3'd4;

  // staged byte slots
  localparam logic [1:0] ByteChargeState = 2'd0;
  localparam logic [1:0] ByteTemperature = 2'd1;
  localparam logic [1:0] ByteSources     = 2'd2;
  localparam logic [1:0] ByteMode        = 2'd3;

  localparam int FlagCleaning  = 0;
  localparam int FlagDocked    = 1;
  localparam int FlagReturning = 2;
  localparam logic [2:0] FlagsReturningMask = 3'b100;
  localparam logic [2:0] FlagsDockedOnly    = 3'b010;

  // element IDs
  localparam logic [7:0] IdGroup0       = 8'd0;
  localparam logic [7:0] IdGroup1       = 8'd1;
  localparam logic [7:0] IdBumpDrop     = 8'd7;
  localparam logic [7:0] IdVirtualWall  = 8'd13;
  localparam logic [7:0] IdAuxSkip      = 8'd128;
  localparam logic [7:0] IdDistance     = 8'd19;
  localparam logic [7:0] IdChargeState  = 8'd21;
  localparam logic [7:0] IdVoltage      = 8'd22;
  localparam logic [7:0] IdCurrent      = 8'd23;
  localparam logic [7:0] IdTemperature  = 8'd24;
  localparam logic [7:0] IdCharge       = 8'd25;
  localparam logic [7:0] IdCapacity     = 8'd26;
  localparam logic [7:0] IdSources      = 8'd34;
  localparam logic [7:0] IdMode         = 8'd35;

  localparam logic [4:0] LenGroup0 = 5'd26;
  localparam logic [4:0] LenGroup1 = 5'd10;
  localparam logic [4:0] LenWord   = 5'd2;
  localparam logic [4:0] LenByte   = 5'd1;
  localparam logic [4:0] LenNone   = 5'd0;

  typedef struct packed {
    logic       hit;
    logic [2:0] idx;
  } word_slot_t;

  typedef struct packed {
    logic       hit;
    logic [1:0] idx;
  } byte_slot_t;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] packet_byte;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    logic signed [15:0] cleaning_limit;
    logic signed [15:0] docked_limit;
  } cfg_t;

  typedef struct packed {
    logic                          done;
    logic                          ok;
    logic [NumWords-1:0][15:0]     words;
    logic [NumBytes-1:0][7:0]      bytes;
  } parse_t;

  typedef struct packed {
    logic               accepted;
    logic signed [15:0] distance_mm;
    logic [7:0]         charge_state_code;
    logic [15:0]        voltage_mv;
    logic signed [15:0] current_ma;
    logic signed [15:0] charge_mah;
    logic [15:0]        capacity_mah;
    logic [7:0]         temperature;
    logic [7:0]         sources_available;
    logic [7:0]         interface_mode;
    logic [2:0]         activity_flags;
  } result_t;

  // payload length of an element, zero for an unknown ID
  function automatic logic [4:0] id_length(input logic [7:0] id);
    logic [4:0] len;
    case (id)
      IdGroup0: len = LenGroup0;
      IdGroup1: len = LenGroup1;
      IdBumpDrop, IdVirtualWall, IdAuxSkip: len = LenByte;
      IdDistance, IdVoltage, IdCurrent, IdCharge, IdCapacity: len = LenWord;
      IdChargeState, IdTemperature, IdSources, IdMode: len = LenByte;
      default: len = LenNone;
    endcase
    return len;
  endfunction

  function automatic word_slot_t word_slot(input logic [7:0] id);
    word_slot_t s;
    s.hit = 1'b1;
    case (id)
      IdDistance: s.idx = WordDistance;
      IdVoltage:  s.idx = WordVoltage;
      IdCurrent:  s.idx = WordCurrent;
      IdCharge:   s.idx = WordCharge;
      IdCapacity: s.idx = WordCapacity;
      default: begin
        s.hit = 1'b0;
        s.idx = WordDistance;
      end
    endcase
    return s;
  endfunction

  function automatic byte_slot_t byte_slot(input logic [7:0] id);
    byte_slot_t s;
    s.hit = 1'b1;
    case (id)
      IdChargeState: s.idx = ByteChargeState;
      IdTemperature: s.idx = ByteTemperature;
      IdSources:     s.idx = ByteSources;
      IdMode:        s.idx = ByteMode;
      default: begin
        s.hit = 1'b0;
        s.idx = ByteChargeState;
      end
    endcase
    return s;
  endfunction

endpackage

[sv/rssp_if.sv]
// Valid/ready channel interfaces for packet items and parse results.
// Depends on nothing; field widths follow rssp_pkg.
interface rssp_item_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] packet_byte;
  logic       last_byte;

  modport source(output valid, command, packet_byte, last_byte, input ready);
  modport sink(input valid, command, packet_byte, last_byte, output ready);
endinterface

interface rssp_result_if;
  logic               valid;
  logic               ready;
  logic               accepted;
  logic signed [15:0] distance_mm;
  logic [7:0]         charge_state_code;
  logic [15:0]        voltage_mv;
  logic signed [15:0] current_ma;
  logic signed [15:0] charge_mah;
  logic [15:0]        capacity_mah;
  logic [7:0]         temperature;
  logic [7:0]         sources_available;
  logic [7:0]         interface_mode;
  logic [2:0]         activity_flags;

  modport source(output valid, accepted, distance_mm, charge_state_code, voltage_mv,
                 current_ma, charge_mah, capacity_mah, temperature, sources_available,
                 interface_mode, activity_flags, input ready);
  modport sink(input valid, accepted, distance_mm, charge_state_code, voltage_mv,
               current_ma, charge_mah, capacity_mah, temperature, sources_available,
               interface_mode, activity_flags, output ready);
endinterface

[sv/rssp_cfg_regs.sv]
// APB-style register file holding the two current thresholds.
// Depends on rssp_pkg.
module rssp_cfg_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rssp_pkg::AddrBits-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output rssp_pkg::cfg_t                cfg
);

  logic reg_sel;
  logic wr;

  assign pready  = 1'b1;
  assign reg_sel = paddr[rssp_pkg::RegIndexBit];
  assign wr      = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cleaning_limit <= rssp_pkg::CleaningLimitReset;
      cfg.docked_limit   <= rssp_pkg::DockedLimitReset;
    end else if (wr) begin
      if (reg_sel == rssp_pkg::CfgCleaningLimit) begin
        cfg.cleaning_limit <= pwdata[15:0];
      end else begin
        cfg.docked_limit <= pwdata[15:0];
      end
    end
  end

  always_comb begin
    if (reg_sel == rssp_pkg::CfgCleaningLimit) begin
      prdata = {{16{cfg.cleaning_limit[15]}}, cfg.cleaning_limit};
    end else begin
      prdata = {{16{cfg.docked_limit[15]}}, cfg.docked_limit};
    end
  end

endmodule

[sv/rssp_parser.sv]
// Element walker: tracks ID and payload position, stages captured fields.
// Depends on rssp_pkg.
module rssp_parser (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic [7:0]       packet_byte,
  input  logic             last_byte,
  output rssp_pkg::parse_t parse
);

  logic                                   expect_id, expect_id_next;
  logic [7:0]                             element_id, element_id_next;
  logic [4:0]                             bytes_left, bytes_left_next;
  logic [7:0]                             high_byte_latch, high_byte_latch_next;
  logic                                   packet_failed, packet_failed_next;
  logic [rssp_pkg::NumWords-1:0][15:0]    staged_words, staged_words_next;
  logic [rssp_pkg::NumBytes-1:0][7:0]     staged_bytes, staged_bytes_next;

  rssp_pkg::word_slot_t ws;
  rssp_pkg::byte_slot_t bs;
  logic [4:0]           len;
  logic [4:0]           left_dec;

  always_comb begin
    ws       = rssp_pkg::word_slot(element_id);
    bs       = rssp_pkg::byte_slot(element_id);
    len      = rssp_pkg::id_length(packet_byte);
    left_dec = (bytes_left != 5'd0) ? bytes_left - 5'd1 : 5'd0;

    expect_id_next       = expect_id;
    element_id_next      = element_id;
    bytes_left_next      = bytes_left;
    high_byte_latch_next = high_byte_latch;
    packet_failed_next   = packet_failed;
    staged_words_next    = staged_words;
    staged_bytes_next    = staged_bytes;

    if (!packet_failed) begin
      if (expect_id) begin
        if (len == rssp_pkg::LenNone) begin
          packet_failed_next = 1'b1;
        end else begin
          element_id_next = packet_byte;
          bytes_left_next = len;
          expect_id_next  = 1'b0;
        end
      end else begin
        if (ws.hit) begin
          if (bytes_left == rssp_pkg::LenWord) begin
            high_byte_latch_next = packet_byte;
          end else begin
            staged_words_next[ws.idx] = {high_byte_latch, packet_byte};
          end
        end else if (bs.hit) begin
          staged_bytes_next[bs.idx] = packet_byte;
        end
        bytes_left_next = left_dec;
        if (left_dec == 5'd0) begin
          expect_id_next = 1'b1;
        end
      end
    end

    parse.done  = step && last_byte;
    parse.ok    = !packet_failed_next && expect_id_next &&
                  (staged_bytes_next[rssp_pkg::ByteTemperature] != 8'd0);
    parse.words = staged_words_next;
    parse.bytes = staged_bytes_next;
  end

  // last byte ends the packet: back to packet-start state
  always_ff @(posedge clk) begin
    if (rst || (step && last_byte)) begin
      expect_id       <= 1'b1;
      element_id      <= 8'd0;
      bytes_left      <= 5'd0;
      high_byte_latch <= 8'd0;
      packet_failed   <= 1'b0;
      staged_words    <= '0;
      staged_bytes    <= '0;
    end else if (step) begin
      expect_id       <= expect_id_next;
      element_id      <= element_id_next;
      bytes_left      <= bytes_left_next;
      high_byte_latch <= high_byte_latch_next;
      packet_failed   <= packet_failed_next;
      staged_words    <= staged_words_next;
      staged_bytes    <= staged_bytes_next;
    end
  end

endmodule

[sv/rssp_out_buf.sv]
// Two-entry result buffer (output register plus skid) driving the result channel.
// Depends on rssp_pkg and rssp_if.
module rssp_out_buf (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  rssp_pkg::result_t push_data,
  output logic              push_ready,
  rssp_result_if.source     result
);

  logic              main_valid;
  logic              skid_valid;
  rssp_pkg::result_t main_data;
  rssp_pkg::result_t skid_data;
  logic              drain;

  assign push_ready = !skid_valid;
  assign drain      = main_valid && result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!main_valid || drain) begin
      if (skid_valid) begin
        main_valid <= 1'b1;
        main_data  <= skid_data;
        skid_valid <= 1'b0;
      end else begin
        main_valid <= push;
        main_data  <= push_data;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
      skid_data  <= push_data;
    end
  end

  assign result.valid             = main_valid;
  assign result.accepted          = main_data.accepted;
  assign result.distance_mm       = main_data.distance_mm;
  assign result.charge_state_code = main_data.charge_state_code;
  assign result.voltage_mv        = main_data.voltage_mv;
  assign result.current_ma        = main_data.current_ma;
  assign result.charge_mah        = main_data.charge_mah;
  assign result.capacity_mah      = main_data.capacity_mah;
  assign result.temperature       = main_data.temperature;
  assign result.sources_available = main_data.sources_available;
  assign result.interface_mode    = main_data.interface_mode;
  assign result.activity_flags    = main_data.activity_flags;

endmodule

[sv/robot_sensor_packet_parser.sv]
// Sensor-stream packet parser: top level with input stage, commit and flag logic.
// Depends on rssp_pkg, rssp_if, rssp_cfg_regs, rssp_parser and rssp_out_buf.
//
// Usage:
//   item channel: one transfer per packet byte (command 0) or host command
//   (1 sets, 2 clears the returning flag). last_byte marks the packet end.
//   result channel: one transfer per packet, on its last byte, carrying the
//   committed fields, activity flags and whether the packet was accepted.
//   APB port: threshold registers at 0x0 (cleaning) and 0x4 (docked);
//   write only while no item is in flight.
// Timing: an item is captured in the input register, then parsed and
//   committed while held there; its result is registered in the result
//   buffer and then shown on the result channel. The single input register
//   feeding the parse logic sets the rate: one item per cycle until a stall.
// Reset: parse state, committed fields and flags clear; thresholds return
//   to -400 mA and -50 mA. No clearing pass.
// Stall: results queue in a two-entry buffer; while both entries hold a
//   result, a held input item stops advancing and item ready drops.
module robot_sensor_packet_parser (
  input  logic                          clk,
  input  logic                          rst,
  rssp_item_if.sink                     item,
  rssp_result_if.source                 result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rssp_pkg::AddrBits-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  rssp_pkg::cfg_t    cfg;
  rssp_pkg::parse_t  parse;
  rssp_pkg::item_t   inq;
  rssp_pkg::result_t push_data;
  logic              inq_valid;
  logic              advance;
  logic              push_ready;
  logic              step;
  logic              commit;
  logic signed [15:0] cur;

  logic [rssp_pkg::NumWords-1:0][15:0] committed_words, committed_words_next;
  logic [rssp_pkg::NumBytes-1:0][7:0]  committed_bytes, committed_bytes_next;
  logic [2:0]                          flags, flags_next;

  rssp_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // input stage
  assign advance    = inq_valid && push_ready;
  assign item.ready = !inq_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      inq_valid <= 1'b0;
    end else if (item.ready) begin
      inq_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      inq.command     <= item.command;
      inq.packet_byte <= item.packet_byte;
      inq.last_byte   <= item.last_byte;
    end
  end

  assign step = advance && (inq.command == rssp_pkg::CMD_PACKET);

  rssp_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .packet_byte (inq.packet_byte),
    .last_byte   (inq.last_byte),
    .parse       (parse)
  );

  assign commit = parse.done && parse.ok;
  assign cur    = parse.words[rssp_pkg::WordCurrent];

  always_comb begin
    committed_words_next = committed_words;
    committed_bytes_next = committed_bytes;
    flags_next           = flags;
    if (advance) begin
      case (inq.command)
        rssp_pkg::CMD_SET_RETURN:   flags_next[rssp_pkg::FlagReturning] = 1'b1;
        rssp_pkg::CMD_CLEAR_RETURN: flags_next[rssp_pkg::FlagReturning] = 1'b0;
        rssp_pkg::CMD_PACKET: begin
          if (commit) begin
            committed_words_next = parse.words;
            committed_bytes_next = parse.bytes;
            flags_next           = flags & rssp_pkg::FlagsReturningMask;
            if (cur < cfg.cleaning_limit) begin
              flags_next[rssp_pkg::FlagCleaning] = 1'b1;
            end else if (cur > cfg.docked_limit) begin
              // docking ends a return trip
              flags_next = rssp_pkg::FlagsDockedOnly;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      committed_words <= '0;
      committed_bytes <= '0;
      flags           <= 3'd0;
    end else begin
      committed_words <= committed_words_next;
      committed_bytes <= committed_bytes_next;
      flags           <= flags_next;
    end
  end

  always_comb begin
    push_data.accepted          = parse.ok;
    push_data.distance_mm       = committed_words_next[rssp_pkg::WordDistance];
    push_data.charge_state_code = committed_bytes_next[rssp_pkg::ByteChargeState];
    push_data.voltage_mv        = committed_words_next[rssp_pkg::WordVoltage];
    push_data.current_ma        = committed_words_next[rssp_pkg::WordCurrent];
    push_data.charge_mah        = committed_words_next[rssp_pkg::WordCharge];
    push_data.capacity_mah      = committed_words_next[rssp_pkg::WordCapacity];
    push_data.temperature       = committed_bytes_next[rssp_pkg::ByteTemperature];
    push_data.sources_available = committed_bytes_next[rssp_pkg::ByteSources];
    push_data.interface_mode    = committed_bytes_next[rssp_pkg::ByteMode];
    push_data.activity_flags    = flags_next;
  end

  rssp_out_buf u_out (
    .clk        (clk),
    .rst        (rst),
    .push       (parse.done),
    .push_data  (push_data),
    .push_ready (push_ready),
    .result     (result)
  );

`ifndef NO_ASSERTIONS
  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(flags[rssp_pkg::FlagCleaning] && flags[rssp_pkg::FlagDocked]))
    else $error("cleaning and docked set together");

  a_dock_clears_return: assert property (@(posedge clk) disable iff (rst)
    commit |=> !(flags[rssp_pkg::FlagDocked] && flags[rssp_pkg::FlagReturning]))
    else $error("docked commit left returning set");

  a_accept_temp: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.accepted |-> result.temperature != 8'd0)
    else $error("accepted result with zero temperature");

  a_inq_hold: assert property (@(posedge clk) disable iff (rst)
    inq_valid && !advance |=> inq_valid && $stable(inq))
    else $error("input register lost a stalled item");
`endif

endmodule
